/* hw/rtl/nonbonded_pair_force_energy_macros.svh */
// Assertion macros for the nonbonded pair force and energy block.
// Used by the port checker; no other dependencies.
`ifndef NONBONDED_PAIR_FORCE_ENERGY_MACROS_SVH
`define NONBONDED_PAIR_FORCE_ENERGY_MACROS_SVH

// same-cycle implication, disabled in reset
`define NBPFE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NBPFE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/nbpfe_pkg.sv */
// Shared types and constants for the nonbonded pair force and energy block.
// No dependencies.
package nbpfe_pkg;

    localparam logic [63:0] SAT_MAG         = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] COULOMB_K       = {32'd331, 32'd3614665651};
    localparam logic [31:0] CUTOFF_SQ_RESET = 32'd9437184;
    localparam int          LJ_FORCE_FACTOR = 12;

    localparam int FRAC_Q     = 32;
    localparam int FRAC_FORCE = 16;

    localparam int LAT_MUL    = 3;
    localparam int DIV_STEPS  = 64;
    localparam int LAT_DIV    = DIV_STEPS + 1;
    localparam int SQRT_STEPS = 32;
    localparam int LAT_SQRT   = SQRT_STEPS;

    typedef enum logic [1:0] {
        SPEC_NORMAL,
        SPEC_ZERO,
        SPEC_SAT
    } spec_t;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [31:0]        eps_root_a;
        logic [31:0]        eps_root_b;
        logic [31:0]        sig_root_a;
        logic [31:0]        sig_root_b;
        logic signed [31:0] charge_a;
        logic signed [31:0] charge_b;
        logic               with_coulomb;
    } in_t;

    typedef struct packed {
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic signed [63:0] force_z;
        logic signed [63:0] pair_energy;
        logic               in_range;
        logic               r_zero;
    } out_t;

    typedef struct packed {
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
        logic        nx;
        logic        ny;
        logic        nz;
        logic        coul;
        logic        cneg;
        logic        inr;
        logic        zero;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } sm_t;

endpackage

/* hw/rtl/nonbonded_pair_force_energy.sv */
// Top level of the nonbonded pair force and energy pipeline.
// Depends on nbpfe_pkg, nbpfe_delay, nbpfe_mulq, nbpfe_div and nbpfe_sqrt.
//
// One atom pair per beat enters on the s_ channel and one result beat leaves on m_, one
// pair per cycle unless stalled. Latency is set by the chain squared sigma, sigma^2/r2
// divide (65 stages), three multiplies for t^6, the epsilon multiply and the force divide
// by r2 (65 stages); the square root and the two Coulomb divides run beside it. The whole
// pipeline holds only when a result waits at the output and the last stage carries a
// valid pair; bubbles are squeezed out otherwise. cutoff_sq is written through cfg_wr_en
// and cfg_wr_data; the user must do so only while the block is idle; it is not enforced.
module nonbonded_pair_force_energy (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nbpfe_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nbpfe_pkg::out_t   m_data,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data
);

    localparam int LM     = nbpfe_pkg::LAT_MUL;
    localparam int LD     = nbpfe_pkg::LAT_DIV;
    localparam int LS     = nbpfe_pkg::LAT_SQRT;
    localparam int P_C    = 3;
    localparam int P_S2   = P_C + LM;
    localparam int P_R    = P_C + LS;
    localparam int P_T    = P_S2 + LD;
    localparam int P_TT   = P_T + LM;
    localparam int P_T3   = P_TT + LM;
    localparam int P_T6   = P_T3 + LM;
    localparam int P_DIFF = P_T6 + 1;
    localparam int P_PRE  = P_DIFF + LM;
    localparam int P_FS   = P_PRE + LD;
    localparam int P_CO   = P_T + LD;
    localparam int P_ADD  = P_FS + 1;
    localparam int P_FC   = P_ADD + LM;
    localparam int P_OUT  = P_FC + 1;
    localparam int SW     = nbpfe_pkg::SIDE_W;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic nbpfe_pkg::sm_t sm_add(input nbpfe_pkg::sm_t a, input nbpfe_pkg::sm_t b);
        nbpfe_pkg::sm_t r;
        logic [64:0]    sum;
        sum = {1'b0, a.mag} + {1'b0, b.mag};
        if (a.mag == nbpfe_pkg::SAT_MAG) begin
            r = a;
        end else if (b.mag == nbpfe_pkg::SAT_MAG) begin
            r = b;
        end else if (a.neg == b.neg) begin
            r.neg = a.neg;
            r.mag = sum[64] ? nbpfe_pkg::SAT_MAG : sum[63:0];
        end else if (a.mag >= b.mag) begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end else begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        return r;
    endfunction

    function automatic logic [63:0] to_out(input logic neg, input logic [63:0] mag);
        logic [63:0] r;
        if (mag == '0) begin
            r = '0;
        end else if (!neg) begin
            r = mag[63] ? nbpfe_pkg::INT64_MAX : mag;
        end else begin
            r = mag[63] ? nbpfe_pkg::INT64_MIN : (~mag + 64'd1);
        end
        return r;
    endfunction

    logic              adv;
    logic [P_OUT-1:0]  vld_reg;
    logic              m_valid_reg;
    nbpfe_pkg::out_t   m_data_reg;
    logic [31:0]       cutoff_sq_reg;

    // stage A
    nbpfe_pkg::side_t  side_a_reg, side_a_next;
    logic [31:0]       mqa_reg, mqb_reg, epsa_reg, epsb_reg, siga_reg, sigb_reg;
    // stage B
    nbpfe_pkg::side_t  side_b_reg;
    logic [63:0]       sqx_reg, sqy_reg, sqz_reg, epsp_reg, sigp_reg, qmp_reg;
    // stage C
    nbpfe_pkg::side_t  side_c_reg, side_c_next;
    logic [63:0]       r2_reg, r2_next, eps_reg, eps_next, eps12_reg, sig_reg, qm_reg;

    logic [31:0] root;
    logic [63:0] r_q, s2, kq, r2_s2, t, q1, kq_t, r_t, cf_mag, ce_mag;
    logic [63:0] tt, t_tt, t3, t6, t3_t6;
    logic [127:0] eps_pair;
    logic [63:0] fpre, es_mag, r2_pre, fs_mag, es_mag_fs;
    logic [1:0]  neg_fs;
    logic [127:0] co_fs;
    logic [SW-1:0] side_fs_bits, side_fc_bits;
    nbpfe_pkg::side_t side_fs, side_fc;

    nbpfe_pkg::sm_t df_reg, df_next, de_reg, de_next;
    nbpfe_pkg::sm_t fs_reg, fs_next, es_reg, es_next;
    nbpfe_pkg::side_t side_add_reg;
    logic [63:0] mfx, mfy, mfz;
    logic [65:0] fin;
    nbpfe_pkg::out_t res_reg, res_next;
    logic [63:0] sub2;

    assign adv     = m_ready || !m_valid_reg || !vld_reg[P_OUT-1];
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_sq_reg <= nbpfe_pkg::CUTOFF_SQ_RESET;
        end else if (cfg_wr_en) begin
            cutoff_sq_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[P_OUT-2:0], s_valid};
            end
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= vld_reg[P_OUT-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= res_reg;
        end
    end

    always_comb begin
        side_a_next      = '0;
        side_a_next.mx   = mag32(s_data.dx);
        side_a_next.my   = mag32(s_data.dy);
        side_a_next.mz   = mag32(s_data.dz);
        side_a_next.nx   = s_data.dx[31];
        side_a_next.ny   = s_data.dy[31];
        side_a_next.nz   = s_data.dz[31];
        side_a_next.coul = s_data.with_coulomb;
        side_a_next.cneg = s_data.charge_a[31] ^ s_data.charge_b[31];
    end

    always_comb begin
        r2_next          = sqx_reg + sqy_reg + sqz_reg;
        eps_next         = {16'd0, epsp_reg[63:16]};
        side_c_next      = side_b_reg;
        side_c_next.zero = (r2_next == '0);
        side_c_next.inr  = (r2_next != '0) && (r2_next < {16'd0, cutoff_sq_reg, 16'd0});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_a_reg <= side_a_next;
            mqa_reg    <= mag32(s_data.charge_a);
            mqb_reg    <= mag32(s_data.charge_b);
            epsa_reg   <= s_data.eps_root_a;
            epsb_reg   <= s_data.eps_root_b;
            siga_reg   <= s_data.sig_root_a;
            sigb_reg   <= s_data.sig_root_b;

            side_b_reg <= side_a_reg;
            sqx_reg    <= {32'd0, side_a_reg.mx} * {32'd0, side_a_reg.mx};
            sqy_reg    <= {32'd0, side_a_reg.my} * {32'd0, side_a_reg.my};
            sqz_reg    <= {32'd0, side_a_reg.mz} * {32'd0, side_a_reg.mz};
            epsp_reg   <= {32'd0, epsa_reg} * {32'd0, epsb_reg};
            sigp_reg   <= {32'd0, siga_reg} * {32'd0, sigb_reg};
            qmp_reg    <= {32'd0, mqa_reg} * {32'd0, mqb_reg};

            side_c_reg <= side_c_next;
            r2_reg     <= r2_next;
            eps_reg    <= eps_next;
            eps12_reg  <= eps_next * 64'(nbpfe_pkg::LJ_FORCE_FACTOR);
            sig_reg    <= {16'd0, sigp_reg[63:16]};
            qm_reg     <= {16'd0, qmp_reg[63:16]};
        end
    end

    nbpfe_sqrt u_sqrt (.aclk(aclk), .en(adv), .din(r2_reg), .root(root));
    assign r_q = {16'd0, root, 16'd0};

    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_Q)) u_mul_s2 (
        .aclk(aclk), .en(adv), .a(sig_reg), .b(sig_reg), .p(s2));
    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_Q)) u_mul_kq (
        .aclk(aclk), .en(adv), .a(nbpfe_pkg::COULOMB_K), .b(qm_reg), .p(kq));
    nbpfe_delay #(.W(64), .N(P_S2 - P_C)) u_dly_r2a (
        .aclk(aclk), .en(adv), .din(r2_reg), .dout(r2_s2));

    nbpfe_div u_div_t  (.aclk(aclk), .en(adv), .num(s2), .den(r2_s2), .quo(t));
    nbpfe_div u_div_q1 (.aclk(aclk), .en(adv), .num(kq), .den(r2_s2), .quo(q1));

    nbpfe_delay #(.W(64), .N(P_T - P_S2)) u_dly_kq (
        .aclk(aclk), .en(adv), .din(kq), .dout(kq_t));
    nbpfe_delay #(.W(64), .N(P_T - P_R)) u_dly_r (
        .aclk(aclk), .en(adv), .din(r_q), .dout(r_t));
    nbpfe_div u_div_cf (.aclk(aclk), .en(adv), .num(q1),   .den(r_t), .quo(cf_mag));
    nbpfe_div u_div_ce (.aclk(aclk), .en(adv), .num(kq_t), .den(r_t), .quo(ce_mag));

    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_Q)) u_mul_tt (
        .aclk(aclk), .en(adv), .a(t), .b(t), .p(tt));
    nbpfe_delay #(.W(64), .N(P_TT - P_T)) u_dly_t (
        .aclk(aclk), .en(adv), .din(t), .dout(t_tt));
    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_Q)) u_mul_t3 (
        .aclk(aclk), .en(adv), .a(tt), .b(t_tt), .p(t3));
    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_Q)) u_mul_t6 (
        .aclk(aclk), .en(adv), .a(t3), .b(t3), .p(t6));
    nbpfe_delay #(.W(64), .N(P_T6 - P_T3)) u_dly_t3 (
        .aclk(aclk), .en(adv), .din(t3), .dout(t3_t6));

    always_comb begin
        sub2 = t3_t6[63] ? nbpfe_pkg::SAT_MAG : {t3_t6[62:0], 1'b0};
        if (t6 == nbpfe_pkg::SAT_MAG) begin
            df_next = '{neg: 1'b0, mag: nbpfe_pkg::SAT_MAG};
            de_next = '{neg: 1'b0, mag: nbpfe_pkg::SAT_MAG};
        end else begin
            df_next = (t6 >= t3_t6) ? '{neg: 1'b0, mag: t6 - t3_t6}
                                    : '{neg: 1'b1, mag: t3_t6 - t6};
            de_next = (t6 >= sub2)  ? '{neg: 1'b0, mag: t6 - sub2}
                                    : '{neg: 1'b1, mag: sub2 - t6};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            df_reg <= df_next;
            de_reg <= de_next;
        end
    end

    nbpfe_delay #(.W(128), .N(P_DIFF - P_C)) u_dly_eps (
        .aclk(aclk), .en(adv), .din({eps12_reg, eps_reg}), .dout(eps_pair));
    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_Q)) u_mul_fpre (
        .aclk(aclk), .en(adv), .a(eps_pair[127:64]), .b(df_reg.mag), .p(fpre));
    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_Q)) u_mul_es (
        .aclk(aclk), .en(adv), .a(eps_pair[63:0]), .b(de_reg.mag), .p(es_mag));
    nbpfe_delay #(.W(64), .N(P_PRE - P_S2)) u_dly_r2b (
        .aclk(aclk), .en(adv), .din(r2_s2), .dout(r2_pre));
    nbpfe_div u_div_fs (.aclk(aclk), .en(adv), .num(fpre), .den(r2_pre), .quo(fs_mag));

    nbpfe_delay #(.W(2), .N(P_FS - P_DIFF)) u_dly_neg (
        .aclk(aclk), .en(adv), .din({df_reg.neg, de_reg.neg}), .dout(neg_fs));
    nbpfe_delay #(.W(64), .N(P_FS - P_PRE)) u_dly_es (
        .aclk(aclk), .en(adv), .din(es_mag), .dout(es_mag_fs));
    nbpfe_delay #(.W(128), .N(P_FS - P_CO)) u_dly_co (
        .aclk(aclk), .en(adv), .din({cf_mag, ce_mag}), .dout(co_fs));
    nbpfe_delay #(.W(SW), .N(P_FS - P_C)) u_dly_side (
        .aclk(aclk), .en(adv), .din(SW'(side_c_reg)), .dout(side_fs_bits));
    assign side_fs = nbpfe_pkg::side_t'(side_fs_bits);

    always_comb begin
        fs_next = '{neg: neg_fs[1], mag: fs_mag};
        es_next = '{neg: neg_fs[0], mag: es_mag_fs};
        if (side_fs.coul) begin
            fs_next = sm_add(fs_next, '{neg: side_fs.cneg, mag: co_fs[127:64]});
            es_next = sm_add(es_next, '{neg: side_fs.cneg, mag: co_fs[63:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fs_reg       <= fs_next;
            es_reg       <= es_next;
            side_add_reg <= side_fs;
        end
    end

    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_FORCE)) u_mul_fx (
        .aclk(aclk), .en(adv), .a({32'd0, side_add_reg.mx}), .b(fs_reg.mag), .p(mfx));
    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_FORCE)) u_mul_fy (
        .aclk(aclk), .en(adv), .a({32'd0, side_add_reg.my}), .b(fs_reg.mag), .p(mfy));
    nbpfe_mulq #(.FRAC(nbpfe_pkg::FRAC_FORCE)) u_mul_fz (
        .aclk(aclk), .en(adv), .a({32'd0, side_add_reg.mz}), .b(fs_reg.mag), .p(mfz));
    nbpfe_delay #(.W(66), .N(P_FC - P_ADD)) u_dly_fin (
        .aclk(aclk), .en(adv), .din({fs_reg.neg, es_reg.neg, es_reg.mag}), .dout(fin));
    nbpfe_delay #(.W(SW), .N(P_FC - P_ADD)) u_dly_side2 (
        .aclk(aclk), .en(adv), .din(SW'(side_add_reg)), .dout(side_fc_bits));
    assign side_fc = nbpfe_pkg::side_t'(side_fc_bits);

    always_comb begin
        res_next          = '0;
        res_next.in_range = side_fc.inr;
        res_next.r_zero   = side_fc.zero;
        if (side_fc.inr) begin
            res_next.force_x     = $signed(to_out(side_fc.nx ^ fin[65], mfx));
            res_next.force_y     = $signed(to_out(side_fc.ny ^ fin[65], mfy));
            res_next.force_z     = $signed(to_out(side_fc.nz ^ fin[65], mfz));
            res_next.pair_energy = $signed(to_out(fin[64], fin[63:0]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

endmodule

/* hw/rtl/nbpfe_delay.sv */
// Enabled delay line of configurable width and depth.
// No dependencies.
module nbpfe_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    generate
        if (N == 0) begin : g_wire
            assign dout = din;
        end else begin : g_line
            logic [W-1:0] tap_reg [N];
            always_ff @(posedge aclk) begin
                if (en) begin
                    tap_reg[0] <= din;
                    for (int i = 1; i < N; i++) begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end
            assign dout = tap_reg[N-1];
        end
    endgenerate

endmodule

/* hw/rtl/nbpfe_mulq.sv */
// Three-stage 64x64 unsigned fixed-point multiplier, truncating, sticky overflow.
// Depends on nbpfe_pkg.
module nbpfe_mulq #(
    parameter int FRAC = nbpfe_pkg::FRAC_Q
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;
    nbpfe_pkg::spec_t spec1_reg, spec1_next;
    logic [64:0] mid_reg;
    logic [63:0] ll2_reg, hh2_reg;
    nbpfe_pkg::spec_t spec2_reg;
    logic [127:0] prod;
    logic [63:0]  p_reg, p_next;

    always_comb begin
        if (a == '0 || b == '0) begin
            spec1_next = nbpfe_pkg::SPEC_ZERO;
        end else if (a == nbpfe_pkg::SAT_MAG || b == nbpfe_pkg::SAT_MAG) begin
            spec1_next = nbpfe_pkg::SPEC_SAT;
        end else begin
            spec1_next = nbpfe_pkg::SPEC_NORMAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg    <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
            lh_reg    <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
            hl_reg    <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
            hh_reg    <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
            spec1_reg <= spec1_next;
            mid_reg   <= {1'b0, lh_reg} + {1'b0, hl_reg};
            ll2_reg   <= ll_reg;
            hh2_reg   <= hh_reg;
            spec2_reg <= spec1_reg;
            p_reg     <= p_next;
        end
    end

    always_comb begin
        prod = {hh2_reg, ll2_reg} + {31'd0, mid_reg, 32'd0};
        unique case (spec2_reg)
            nbpfe_pkg::SPEC_ZERO: p_next = '0;
            nbpfe_pkg::SPEC_SAT:  p_next = nbpfe_pkg::SAT_MAG;
            default: begin
                p_next = (|prod[127:FRAC+64]) ? nbpfe_pkg::SAT_MAG : prod[FRAC+63:FRAC];
            end
        endcase
    end

    assign p = p_reg;

endmodule

/* hw/rtl/nbpfe_div.sv */
// Pipelined restoring divider for Q32.32 magnitudes, one quotient bit per stage.
// Depends on nbpfe_pkg.
module nbpfe_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [63:0] quo
);

    localparam int STEPS = nbpfe_pkg::DIV_STEPS;

    logic [63:0] rem_reg [STEPS+1];
    logic [63:0] w_reg   [STEPS+1];
    logic [63:0] den_reg [STEPS+1];
    nbpfe_pkg::spec_t spec_reg [STEPS+1];
    logic [63:0] rem_next [STEPS];
    logic [63:0] w_next   [STEPS];
    nbpfe_pkg::spec_t spec_next;

    always_comb begin
        if (num == '0) begin
            spec_next = nbpfe_pkg::SPEC_ZERO;
        end else if (num == nbpfe_pkg::SAT_MAG || den == '0 || {32'd0, num[63:32]} >= den) begin
            spec_next = nbpfe_pkg::SPEC_SAT;
        end else begin
            spec_next = nbpfe_pkg::SPEC_NORMAL;
        end
    end

    always_comb begin
        logic [64:0] shifted;
        logic [64:0] diff;
        logic        ge;
        for (int k = 0; k < STEPS; k++) begin
            shifted     = {rem_reg[k], w_reg[k][63]};
            diff        = shifted - {1'b0, den_reg[k]};
            ge          = shifted >= {1'b0, den_reg[k]};
            rem_next[k] = ge ? diff[63:0] : shifted[63:0];
            w_next[k]   = {w_reg[k][62:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {32'd0, num[63:32]};
            w_reg[0]    <= {num[31:0], 32'd0};
            den_reg[0]  <= den;
            spec_reg[0] <= spec_next;
            for (int k = 1; k <= STEPS; k++) begin
                rem_reg[k]  <= rem_next[k-1];
                w_reg[k]    <= w_next[k-1];
                den_reg[k]  <= den_reg[k-1];
                spec_reg[k] <= spec_reg[k-1];
            end
        end
    end

    always_comb begin
        unique case (spec_reg[STEPS])
            nbpfe_pkg::SPEC_ZERO: quo = '0;
            nbpfe_pkg::SPEC_SAT:  quo = nbpfe_pkg::SAT_MAG;
            default:              quo = w_reg[STEPS];
        endcase
    end

endmodule

/* hw/rtl/nbpfe_sqrt.sv */
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on nbpfe_pkg.
module nbpfe_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] din,
    output logic [31:0] root
);

    localparam int STEPS = nbpfe_pkg::SQRT_STEPS;
    localparam int TOP   = 2 * (STEPS - 1);

    logic [63:0] v_reg   [STEPS];
    logic [63:0] res_reg [STEPS];
    logic [63:0] v_next   [STEPS];
    logic [63:0] res_next [STEPS];

    always_comb begin
        logic [63:0] vin;
        logic [63:0] rin;
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                vin = din;
                rin = '0;
            end else begin
                vin = v_reg[(k > 0) ? k - 1 : 0];
                rin = res_reg[(k > 0) ? k - 1 : 0];
            end
            bitv  = 64'd1 << (TOP - 2 * k);
            trial = rin + bitv;
            if (vin >= trial) begin
                v_next[k]   = vin - trial;
                res_next[k] = (rin >> 1) + bitv;
            end else begin
                v_next[k]   = vin;
                res_next[k] = rin >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STEPS; k++) begin
                v_reg[k]   <= v_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign root = res_reg[STEPS-1][31:0];

endmodule

/* hw/rtl/nbpfe_checker.sv */
// Port-level assertions for the nonbonded pair force and energy block, bound to the top.
// Depends on nbpfe_pkg and nonbonded_pair_force_energy_macros.svh.
`include "nonbonded_pair_force_energy_macros.svh"

module nbpfe_port_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input nbpfe_pkg::out_t m_data
);

    `NBPFE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    `NBPFE_ASSERT_NOW(a_zero_excl, aclk, aresetn, m_valid && m_data.r_zero, !m_data.in_range, "zero distance flagged in range")

    `NBPFE_ASSERT_NOW(a_out_of_range, aclk, aresetn, m_valid && !m_data.in_range, m_data.force_x == 64'sd0 && m_data.force_y == 64'sd0 && m_data.force_z == 64'sd0 && m_data.pair_energy == 64'sd0, "nonzero values outside range")

    `NBPFE_ASSERT_NOW(a_stall_src, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output back-pressure")

endmodule

bind nonbonded_pair_force_energy nbpfe_port_checker u_port_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data)
);
